[hdl/tmpd_pkg.sv]
`timescale 1ns / 1ps

package tmpd_pkg;

  localparam logic [2:0] REQ_ATTACH  = 3'd0;
  localparam logic [2:0] REQ_DETACH  = 3'd1;
  localparam logic [2:0] REQ_SET     = 3'd2;
  localparam logic [2:0] REQ_RELEASE = 3'd3;
  localparam logic [2:0] REQ_TICK    = 3'd4;

  localparam logic [1:0] POS_UNKNOWN = 2'd0;
  localparam logic [1:0] POS_CLOSED  = 2'd1;
  localparam logic [1:0] POS_THROWN  = 2'd2;

  // most off commands one tick may issue
  localparam int MAX_RESULTS = 8;
  localparam int CNT_W       = 4;

  typedef struct packed {
    logic        attached;
    logic        pulse_type;
    logic [15:0] pulse_len;
    logic [7:0]  duty;
    logic        reversed;
    logic [1:0]  position;
    logic        pulsing;
    logic [31:0] pulse_start;
  } chan_entry_t;

  typedef struct packed {
    logic        cmd_valid;
    logic [3:0]  cmd_channel;
    logic        cmd_mode;
    logic        cmd_reverse;
    logic [7:0]  cmd_duty;
    logic        status_attached;
    logic [1:0]  status_position;
    logic        status_pulsing;
  } result_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic        thrown;
    logic        motor_is_pulse;
    logic [15:0] pulse_length_ms;
    logic [7:0]  drive_duty;
    logic        wiring_reversed;
  } req_t;

  typedef struct packed {
    logic    expired;
    result_t res;
  } upd_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REQ,
    ST_SCAN,
    ST_FLUSH
  } state_t;

endpackage

[hdl/tmpd_ram.sv]
`timescale 1ns / 1ps

module tmpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic                                       rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hdl/tmpd_chan_update.sv]
`timescale 1ns / 1ps

module tmpd_chan_update (
  input  logic                 scan,
  input  tmpd_pkg::req_t       req,
  input  logic [3:0]           chan,
  input  tmpd_pkg::chan_entry_t cur,
  input  logic [31:0]          now_ms,
  output tmpd_pkg::chan_entry_t nxt,
  output tmpd_pkg::upd_out_t   upd
);
  import tmpd_pkg::*;

  logic [31:0] elapsed;

  assign elapsed = now_ms - cur.pulse_start;

  always_comb begin
    nxt             = cur;
    upd             = '0;
    upd.res.cmd_channel = chan;
    if (scan) begin
      upd.expired = cur.pulsing && (elapsed >= {16'b0, cur.pulse_len});
      if (upd.expired) begin
        nxt.pulsing       = 1'b0;
        upd.res.cmd_valid = 1'b1;
      end
    end else begin
      unique case (req.req_type)
        REQ_ATTACH: begin
          nxt.attached   = 1'b1;
          nxt.pulse_type = req.motor_is_pulse;
          nxt.pulse_len  = req.pulse_length_ms;
          nxt.duty       = req.drive_duty;
          nxt.reversed   = req.wiring_reversed;
          if (!cur.attached) begin
            nxt.position = POS_UNKNOWN;
            nxt.pulsing  = 1'b0;
          end else if (!req.motor_is_pulse && cur.position != POS_UNKNOWN) begin
            // re-drive a stall motor at its known position
            nxt.pulsing         = 1'b0;
            upd.res.cmd_valid   = 1'b1;
            upd.res.cmd_mode    = 1'b1;
            upd.res.cmd_reverse = (cur.position == POS_THROWN) ^ req.wiring_reversed;
            upd.res.cmd_duty    = req.drive_duty;
          end else if (req.motor_is_pulse && !cur.pulsing) begin
            upd.res.cmd_valid = 1'b1;
          end
        end
        REQ_DETACH: begin
          nxt.attached = 1'b0;
          nxt.pulsing  = 1'b0;
          nxt.position = POS_UNKNOWN;
        end
        REQ_SET: begin
          if (cur.attached) begin
            nxt.position        = req.thrown ? POS_THROWN : POS_CLOSED;
            upd.res.cmd_valid   = 1'b1;
            upd.res.cmd_mode    = 1'b1;
            upd.res.cmd_reverse = req.thrown ^ cur.reversed;
            upd.res.cmd_duty    = cur.duty;
            if (cur.pulse_type) begin
              nxt.pulsing     = 1'b1;
              nxt.pulse_start = now_ms;
            end
          end
        end
        REQ_RELEASE: begin
          nxt.pulsing = 1'b0;
        end
        default: begin
        end
      endcase
    end
    upd.res.status_attached = nxt.attached;
    upd.res.status_position = nxt.position;
    upd.res.status_pulsing  = nxt.pulsing;
  end

endmodule

[hdl/turnout_motor_pulse_driver.sv]
`timescale 1ns / 1ps
// Channel   Dir  tdata                                 tuser      tlast
// s_axis    in   request fields, 32 bits               req_type   -
// m_axis    out  command and channel status, 24 bits   cmd_valid  last result of item
//
// A channel request does one memory read, then one read-modify-write.
// A tick walks the channel memory one entry per cycle unless a stall holds the
// walk, read of the next entry overlapping the write of the current one.
// Reset clears the time counter, the control state and a valid bit per entry;
// an entry never written reads as all zero. Output stalls hold the walk only
// when a second off command has to leave while the output register is full.
module turnout_motor_pulse_driver #(
  parameter int CHANNEL_COUNT = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [3:0] channel, [4] thrown, [5] motor_is_pulse, [21:6] pulse_length_ms,
  // [29:22] drive_duty, [30] wiring_reversed, [31] zero
  input  logic [31:0] s_axis_tdata,
  // [2:0] req_type
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [3:0] cmd_channel, [4] cmd_mode, [5] cmd_reverse, [13:6] cmd_duty,
  // [14] status_attached, [16:15] status_position, [17] status_pulsing, [23:18] zero
  output logic [23:0] m_axis_tdata,
  // [0] cmd_valid
  output logic        m_axis_tuser,
  output logic        m_axis_tlast
);
  import tmpd_pkg::*;

  localparam int AW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam logic [4:0]    CH_LIMIT = 5'(CHANNEL_COUNT);
  localparam logic [AW-1:0] LAST_IDX = AW'(CHANNEL_COUNT - 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RESULTS);

  state_t             state, state_next;
  logic [31:0]        now_ms, now_ms_next;
  req_t               req, req_next;
  logic [AW-1:0]      cur_idx, cur_idx_next;
  logic [CNT_W-1:0]   scan_cnt, scan_cnt_next;
  logic               hold_valid, hold_valid_next;
  result_t            hold, hold_next;
  logic               out_valid, out_valid_next;
  result_t            out_res, out_res_next;
  logic               out_last, out_last_next;
  logic [CHANNEL_COUNT-1:0] vld;

  logic               rd_en, wr_en;
  logic [AW-1:0]      rd_addr;
  chan_entry_t        rd_data, cur_entry, nxt_entry;
  upd_out_t           upd;
  logic               accept, push_ok, in_range, take;

  tmpd_ram #(
    .WIDTH ($bits(chan_entry_t)),
    .DEPTH (CHANNEL_COUNT)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cur_idx),
    .wr_data (nxt_entry),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign cur_entry = vld[cur_idx] ? rd_data : '0;

  tmpd_chan_update u_upd (
    .scan   (state == ST_SCAN),
    .req    (req),
    .chan   (4'(cur_idx)),
    .cur    (cur_entry),
    .now_ms (now_ms),
    .nxt    (nxt_entry),
    .upd    (upd)
  );

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign push_ok  = !out_valid || m_axis_tready;
  assign in_range = {1'b0, s_axis_tdata[3:0]} < CH_LIMIT;
  assign take     = upd.expired && (scan_cnt < CNT_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      now_ms     <= '0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
      scan_cnt   <= '0;
      vld        <= '0;
    end else begin
      state      <= state_next;
      now_ms     <= now_ms_next;
      hold_valid <= hold_valid_next;
      out_valid  <= out_valid_next;
      scan_cnt   <= scan_cnt_next;
      if (wr_en) begin
        vld[cur_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    req      <= req_next;
    cur_idx  <= cur_idx_next;
    hold     <= hold_next;
    out_res  <= out_res_next;
    out_last <= out_last_next;
  end

  always_comb begin
    state_next      = state;
    now_ms_next     = now_ms;
    req_next        = req;
    cur_idx_next    = cur_idx;
    scan_cnt_next   = scan_cnt;
    hold_valid_next = hold_valid;
    hold_next       = hold;
    out_valid_next  = out_valid && !m_axis_tready;
    out_res_next    = out_res;
    out_last_next   = out_last;
    rd_en           = 1'b0;
    rd_addr         = cur_idx;
    wr_en           = 1'b0;
    s_axis_tready   = 1'b0;

    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (accept) begin
          req_next = {s_axis_tuser, s_axis_tdata[4], s_axis_tdata[5],
                      s_axis_tdata[21:6], s_axis_tdata[29:22], s_axis_tdata[30]};
          if (s_axis_tuser == REQ_TICK) begin
            now_ms_next   = now_ms + 32'd1;
            rd_en         = 1'b1;
            rd_addr       = '0;
            cur_idx_next  = '0;
            scan_cnt_next = '0;
            state_next    = ST_SCAN;
          end else if (s_axis_tuser <= REQ_RELEASE && in_range) begin
            rd_en        = 1'b1;
            rd_addr      = s_axis_tdata[AW-1:0];
            cur_idx_next = s_axis_tdata[AW-1:0];
            state_next   = ST_REQ;
          end
        end
      end
      ST_REQ: begin
        if (push_ok) begin
          wr_en          = 1'b1;
          out_valid_next = 1'b1;
          out_res_next   = upd.res;
          out_last_next  = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      ST_SCAN: begin
        // hold the walk while an earlier off command cannot leave
        if (!(take && hold_valid && !push_ok)) begin
          if (take) begin
            wr_en = 1'b1;
            if (hold_valid) begin
              out_valid_next = 1'b1;
              out_res_next   = hold;
              out_last_next  = 1'b0;
            end
            hold_valid_next = 1'b1;
            hold_next       = upd.res;
            scan_cnt_next   = scan_cnt + 1'b1;
          end
          if (cur_idx == LAST_IDX) begin
            state_next = ST_FLUSH;
          end else begin
            rd_en        = 1'b1;
            rd_addr      = cur_idx + 1'b1;
            cur_idx_next = cur_idx + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (!hold_valid) begin
          state_next = ST_IDLE;
        end else if (push_ok) begin
          out_valid_next  = 1'b1;
          out_res_next    = hold;
          out_last_next   = 1'b1;
          hold_valid_next = 1'b0;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.cmd_valid;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {6'b0, out_res.status_pulsing, out_res.status_position,
                          out_res.status_attached, out_res.cmd_duty, out_res.cmd_reverse,
                          out_res.cmd_mode, out_res.cmd_channel};

endmodule

[hdl/tmpd_checker.sv]
`timescale 1ns / 1ps

module tmpd_checker #(
  parameter int CHANNEL_COUNT = 8
) (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [31:0] s_axis_tdata,
  input logic [2:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);
  import tmpd_pkg::*;

  localparam logic [4:0] CH_LIMIT = 5'(CHANNEL_COUNT);

  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  // nothing leaves right after reset
  a_reset_idle: assert property (@(posedge clk) !rst && $past(rst) |-> !m_axis_tvalid)
    else $error("result beat presented right after reset");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("stalled result beat changed");

  // a tick or an in-range request keeps the input closed for the next cycle
  a_busy_after_work: assert property (@(posedge clk) disable iff (rst)
    s_acc && (s_axis_tuser == REQ_TICK ||
              (s_axis_tuser <= REQ_RELEASE && {1'b0, s_axis_tdata[3:0]} < CH_LIMIT))
      |=> !s_axis_tready)
    else $error("input accepted while previous item still at work");

  // a status-only beat comes from a channel request and ends its item
  a_status_only_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && !m_axis_tdata[4])
    else $error("status-only beat not last or carries drive mode");

endmodule

bind turnout_motor_pulse_driver tmpd_checker #(
  .CHANNEL_COUNT (CHANNEL_COUNT)
) u_tmpd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
